// ----- design/ppe_pkg.sv -----
// Package for the pseudocolour PPM pixel encoder.
// Word types, configuration bundle, register indexes and the decimal split.
// No dependencies.
package ppe_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_HIGH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_ENTRIES  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ASCII_MODE   = 3'd4;

   // ASCII characters
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

   // Channel numbering within a pixel
   localparam logic [1:0] CHAN_RED  = 2'd0;
   localparam logic [1:0] CHAN_BLUE = 2'd2;

   localparam logic [7:0]  GREY_TOP   = 8'hff;
   localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0000_8000;

   // Input word
   typedef struct packed {
      logic              kind;
      logic signed [31:0] sample;
      logic [7:0]        entry_index;
      logic [15:0]       red_entry;
      logic [15:0]       green_entry;
      logic [15:0]       blue_entry;
   } ppe_req_type;

   // Output word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } ppe_rsp_type;

   // Settings seen by the pipeline
   typedef struct packed {
      logic signed [31:0] clip_low;
      logic signed [31:0] clip_high;
      logic [31:0]        scale_factor;
      logic [7:0]         top_index;
      logic               map_mode;
      logic               ascii_mode;
   } ppe_cfg_type;

   // Map load carried alongside a pixel slot
   typedef struct packed {
      logic [7:0]  entry_index;
      logic [23:0] entry_rgb;
   } ppe_load_type;

   // Index stage to lookup stage
   typedef struct packed {
      logic         kind;
      logic [7:0]   map_index;
      ppe_load_type load;
   } ppe_idx_type;

   // Decimal split of one channel byte
   typedef struct packed {
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
      logic [1:0] ndig;
   } ppe_dec_type;

   // Lookup stage to byte sequencer
   typedef struct packed {
      logic [2:0][7:0]  chan;
      ppe_dec_type [2:0] dec;
   } ppe_fmt_type;

   // Byte to decimal digits by reciprocal multiplication (exact for 0..255)
   function automatic ppe_dec_type to_dec(input logic [7:0] value);
      logic [13:0] hund_prod;
      logic [7:0]  rem;
      logic [15:0] tens_prod;
      logic [7:0]  ones_wide;
      ppe_dec_type res;
      hund_prod = 14'(value) * 14'd41;
      res.hund  = {2'b00, hund_prod[13:12]};
      rem       = value - (8'(res.hund) * 8'd100);
      tens_prod = 16'(rem) * 16'd205;
      res.tens  = tens_prod[14:11];
      ones_wide = rem - (8'(res.tens) * 8'd10);
      res.ones  = ones_wide[3:0];
      if (value >= 8'd100)
         res.ndig = 2'd3;
      else if (value >= 8'd10)
         res.ndig = 2'd2;
      else
         res.ndig = 2'd1;
      return res;
   endfunction

endpackage

// ----- design/ppe_index.sv -----
// Index pipeline: clip compare, Q16.16 scale multiply, round and saturate.
// Three register stages; depends on ppe_pkg.
module ppe_index #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ppe_pkg::ppe_cfg_type cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  ppe_pkg::ppe_req_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ppe_pkg::ppe_idx_type out_data
);
   import ppe_pkg::*;

   localparam int EXT_W = 33 - SAMPLE_WIDTH;

   logic rdy1, rdy2, rdy3;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   // stage 1 registers
   logic         kind1_ff, below1_ff, above1_ff;
   logic [31:0]  diff1_ff;
   ppe_load_type load1_ff;
   // stage 2 registers
   logic         kind2_ff, below2_ff, above2_ff;
   logic [63:0]  prod2_ff;
   ppe_load_type load2_ff;
   // stage 3 register
   ppe_idx_type  idx3_ff;

   logic signed [32:0] sample_in, low_in, high_in;
   logic [32:0]        diff_wide;
   logic               below_in, above_in;
   logic [31:0]        diff_in;
   ppe_load_type       load_in;
   logic [63:0]        prod_in;
   logic [63:0]        rounded;
   logic [47:0]        quot;
   logic [7:0]         index_in;
   ppe_idx_type        idx_in;

   // handshake chain
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign v1_in    = rdy1 ? in_valid : v1_ff;
   assign v2_in    = rdy2 ? v1_ff : v2_ff;
   assign v3_in    = rdy3 ? v2_ff : v3_ff;

   // stage 1: sign extend, clip compares, offset from low limit
   assign sample_in = {{EXT_W{in_data.sample[SAMPLE_WIDTH-1]}},
                       in_data.sample[SAMPLE_WIDTH-1:0]};
   assign low_in    = {cfg.clip_low[31], cfg.clip_low};
   assign high_in   = {cfg.clip_high[31], cfg.clip_high};
   assign below_in  = sample_in < low_in;
   assign above_in  = sample_in > high_in;
   assign diff_wide = sample_in - low_in;
   assign diff_in   = diff_wide[31:0];
   assign load_in   = '{entry_index: in_data.entry_index,
                        entry_rgb: {in_data.red_entry[15:8], in_data.green_entry[15:8],
                                    in_data.blue_entry[15:8]}};

   // stage 2: scale multiply
   assign prod_in = 64'(diff1_ff) * 64'(cfg.scale_factor);

   // stage 3: round to nearest, saturate to top index
   assign rounded = prod2_ff + ROUND_HALF;
   assign quot    = rounded[63:16];
   always_comb begin
      if (below2_ff)
         index_in = 8'd0;
      else if (above2_ff || (quot > 48'(cfg.top_index)))
         index_in = cfg.top_index;
      else
         index_in = quot[7:0];
   end
   assign idx_in = '{kind: kind2_ff, map_index: index_in, load: load2_ff};

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         kind1_ff  <= in_data.kind;
         below1_ff <= below_in;
         above1_ff <= above_in;
         diff1_ff  <= diff_in;
         load1_ff  <= load_in;
      end
      if (rdy2 && v1_ff) begin
         kind2_ff  <= kind1_ff;
         below2_ff <= below1_ff;
         above2_ff <= above1_ff;
         prod2_ff  <= prod_in;
         load2_ff  <= load1_ff;
      end
      if (rdy3 && v2_ff) begin
         idx3_ff <= idx_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = idx3_ff;

endmodule

// ----- design/ppe_lookup.sv -----
// Colour map memory and channel formatting: map read or grey, decimal split.
// Two register stages; depends on ppe_pkg.
module ppe_lookup #(
   parameter int MAP_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  ppe_pkg::ppe_cfg_type cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  ppe_pkg::ppe_idx_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ppe_pkg::ppe_fmt_type out_data
);
   import ppe_pkg::*;

   localparam int ADDR_W = $clog2(MAP_DEPTH);

   logic [23:0] map_ff [MAP_DEPTH];

   logic        rdy4, rdy5;
   logic        v4_ff, v5_ff, v4_in, v5_in;
   logic [23:0] rd4_ff;
   logic [7:0]  idx4_ff;
   ppe_fmt_type fmt5_ff, fmt_in;
   logic        load_hit;
   logic [2:0][7:0] chan_sel;

   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;
   // loads end here; only pixels go on
   assign v4_in    = rdy4 ? (in_valid && !in_data.kind) : v4_ff;
   assign v5_in    = rdy5 ? v4_ff : v5_ff;

   assign load_hit = in_valid && in_data.kind &&
                     ({1'b0, in_data.load.entry_index} < 9'(MAP_DEPTH));

   // map access: writes and reads keep item order, one per slot
   always_ff @(posedge clock) begin
      if (rdy4 && load_hit)
         map_ff[in_data.load.entry_index[ADDR_W-1:0]] <= in_data.load.entry_rgb;
      if (rdy4 && in_valid && !in_data.kind) begin
         rd4_ff  <= map_ff[in_data.map_index[ADDR_W-1:0]];
         idx4_ff <= in_data.map_index;
      end
   end

   // channel select and decimal split
   always_comb begin
      if (cfg.map_mode) begin
         chan_sel[0] = rd4_ff[23:16];
         chan_sel[1] = rd4_ff[15:8];
         chan_sel[2] = rd4_ff[7:0];
      end else begin
         chan_sel[0] = idx4_ff;
         chan_sel[1] = idx4_ff;
         chan_sel[2] = idx4_ff;
      end
      fmt_in.chan = chan_sel;
      for (int i = 0; i < 3; i++)
         fmt_in.dec[i] = to_dec(chan_sel[i]);
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff)
         fmt5_ff <= fmt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = fmt5_ff;

endmodule

// ----- design/ppe_serial.sv -----
// Byte sequencer: walks one formatted pixel out as binary or ASCII bytes.
// Ends in the output register; depends on ppe_pkg.
module ppe_serial (
   input  logic                clock,
   input  logic                reset,
   input  ppe_pkg::ppe_cfg_type cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  ppe_pkg::ppe_fmt_type in_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ppe_pkg::ppe_rsp_type rsp_data
);
   import ppe_pkg::*;

   logic [1:0]  chan_ff, chan_in;
   logic [1:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ppe_rsp_type rsp_data_ff, rsp_data_in;

   logic [7:0]  cur_chan;
   ppe_dec_type cur_dec;
   logic [1:0]  digit_sel;
   logic [3:0]  digit;
   logic        last_chan, is_sep, emit;

   assign cur_chan  = in_data.chan[chan_ff];
   assign cur_dec   = in_data.dec[chan_ff];
   assign last_chan = chan_ff == CHAN_BLUE;
   assign is_sep    = pos_ff == cur_dec.ndig;
   // skip leading zeros
   assign digit_sel = pos_ff + (2'd3 - cur_dec.ndig);

   always_comb begin
      case (digit_sel)
         2'd0:    digit = cur_dec.hund;
         2'd1:    digit = cur_dec.tens;
         default: digit = cur_dec.ones;
      endcase
   end

   // next byte and position
   always_comb begin
      chan_in = chan_ff;
      pos_in  = pos_ff;
      if (!cfg.ascii_mode) begin
         rsp_data_in = '{out_byte: cur_chan, last_byte: last_chan};
         chan_in     = last_chan ? CHAN_RED : chan_ff + 2'd1;
         pos_in      = 2'd0;
      end else if (is_sep) begin
         rsp_data_in = '{out_byte: (last_chan ? CHAR_NEWLINE : CHAR_SPACE),
                         last_byte: last_chan};
         chan_in     = last_chan ? CHAN_RED : chan_ff + 2'd1;
         pos_in      = 2'd0;
      end else begin
         rsp_data_in = '{out_byte: CHAR_ZERO + {4'b0000, digit}, last_byte: 1'b0};
         pos_in      = pos_ff + 2'd1;
      end
   end

   assign emit         = in_valid && (!rsp_valid_ff || rsp_ready);
   assign in_ready     = emit && rsp_data_in.last_byte;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= CHAN_RED;
         pos_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            chan_ff <= chan_in;
            pos_ff  <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a pixel is released exactly when its final byte is loaded
   a_release_last: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> rsp_valid_ff && rsp_data_ff.last_byte)
      else $error("pixel released without a final byte");

   // while a final byte waits, the walk is back at its start
   a_walk_rewound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.last_byte |-> chan_ff == CHAN_RED && pos_ff == 2'd0)
      else $error("byte walk not rewound after final byte");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff != 2'd3)
      else $error("channel counter out of range");

   a_binary_pos: assert property (@(posedge clock) disable iff (reset)
      !cfg.ascii_mode |-> pos_ff == 2'd0)
      else $error("digit position moved in binary mode");

endmodule

// ----- design/pseudocolour_ppm_pixel_encoder.sv -----
// Top level of the pseudocolour PPM pixel encoder: registers and pipeline.
// Depends on ppe_pkg, ppe_index, ppe_lookup and ppe_serial.
//
//   port group   dir   handshake            word
//   req_         in    req_valid/req_ready  ppe_req_type (pixel or map load)
//   rsp_         out   rsp_valid/rsp_ready  ppe_rsp_type (one byte, last flag)
//   csr_         in    csr_write            csr_index, csr_wdata
//
// From acceptance to its first byte at rsp_, a word passes the three index
// stages, map read, format and the output register. The byte sequencer sends
// a pixel as 3 bytes in binary mode, 6 to 12 (one per ASCII character) in text
// mode; map loads take one slot and emit nothing. Reset is synchronous and
// clears valid bits, settings and the byte walk; the colour map holds garbage
// until loaded, with no clearing pass. A stall holds each full stage in place.
module pseudocolour_ppm_pixel_encoder #(
   parameter int MAP_DEPTH    = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [ppe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ppe_pkg::ppe_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ppe_pkg::ppe_rsp_type                rsp_data
);
   import ppe_pkg::*;

   logic signed [31:0] clip_low_ff, clip_high_ff;
   logic [31:0]        scale_factor_ff;
   logic [8:0]         map_entries_ff;
   logic               ascii_mode_ff;

   logic [8:0]   used_entries;
   logic [8:0]   used_top;
   logic         map_mode;
   ppe_cfg_type  cfg;

   logic        idx_valid, idx_ready;
   ppe_idx_type idx_data;
   logic        fmt_valid, fmt_ready;
   ppe_fmt_type fmt_data;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_low_ff     <= 32'sd0;
         clip_high_ff    <= 32'sd255;
         scale_factor_ff <= 32'd65536;
         map_entries_ff  <= 9'd256;
         ascii_mode_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CLIP_LOW:     clip_low_ff     <= csr_wdata;
            CSR_CLIP_HIGH:    clip_high_ff    <= csr_wdata;
            CSR_SCALE_FACTOR: scale_factor_ff <= csr_wdata;
            CSR_MAP_ENTRIES:  map_entries_ff  <= csr_wdata[8:0];
            CSR_ASCII_MODE:   ascii_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // map or grey mode and the top index
   assign used_entries = (map_entries_ff > 9'(MAP_DEPTH)) ? 9'(MAP_DEPTH) : map_entries_ff;
   assign map_mode     = used_entries > 9'd2;
   assign used_top     = used_entries - 9'd1;

   assign cfg = '{clip_low: clip_low_ff, clip_high: clip_high_ff,
                  scale_factor: scale_factor_ff,
                  top_index: (map_mode ? used_top[7:0] : GREY_TOP),
                  map_mode: map_mode, ascii_mode: ascii_mode_ff};

   ppe_index #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_index (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (idx_valid),
      .out_ready (idx_ready),
      .out_data  (idx_data)
   );

   ppe_lookup #(.MAP_DEPTH(MAP_DEPTH)) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (idx_valid),
      .in_ready  (idx_ready),
      .in_data   (idx_data),
      .out_valid (fmt_valid),
      .out_ready (fmt_ready),
      .out_data  (fmt_data)
   );

   ppe_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (fmt_valid),
      .in_ready  (fmt_ready),
      .in_data   (fmt_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
